// ===== rtl/core/tcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_pkg - shared types and constants for text character statistics
// Byte classes, queue entry, result record and report layout.
// ----------------------------------------------------------------------------
package tcs_pkg;

    // byte classes produced by the front end
    typedef enum logic [2:0] {
        CLS_UPPER,
        CLS_LOWER,
        CLS_DIGIT,
        CLS_OTHER,
        CLS_NEWLINE,
        CLS_EOT
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [4:0] letter;
    } t_qentry;

    typedef struct packed {
        logic [3:0]  kind;
        logic [4:0]  letter;
        logic [31:0] value;
        logic        last;
    } t_result;

    // stat_kind codes
    localparam logic [3:0] KIND_UPPER     = 4'd0;
    localparam logic [3:0] KIND_LOWER     = 4'd1;
    localparam logic [3:0] KIND_DIGIT     = 4'd2;
    localparam logic [3:0] KIND_OTHER     = 4'd3;
    localparam logic [3:0] KIND_LINES     = 4'd4;
    localparam logic [3:0] KIND_LONGEST   = 4'd5;
    localparam logic [3:0] KIND_SHORTEST  = 4'd6;
    localparam logic [3:0] KIND_UPPER_BIN = 4'd7;
    localparam logic [3:0] KIND_LOWER_BIN = 4'd8;

    // characters
    localparam logic [7:0] CHAR_NL      = 8'h0A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    localparam int unsigned NUM_LETTERS   = 26;
    localparam int unsigned SCALAR_COUNT  = 7;
    localparam int unsigned REPORT_LEN    = SCALAR_COUNT + 2 * NUM_LETTERS;
    localparam int unsigned BIN_DEPTH     = 2 * NUM_LETTERS;
    localparam int unsigned BIN_AW        = $clog2(BIN_DEPTH);
    localparam int unsigned REP_IW        = $clog2(REPORT_LEN);
    localparam int unsigned SHORTEST_INIT = 32'd2097152;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

// ===== rtl/core/tcs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_in_if - text byte channel
// Valid/ready channel carrying one text byte and the end-of-text flag.
// ----------------------------------------------------------------------------
interface tcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/core/tcs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_out_if - statistics result channel
// Valid/ready channel carrying one report entry.
// ----------------------------------------------------------------------------
interface tcs_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  stat_kind;
    logic [4:0]  letter_index;
    logic [31:0] stat_value;
    logic        last_result;

    modport source (output valid, output stat_kind, output letter_index,
                    output stat_value, output last_result, input ready);
    modport sink   (input valid, input stat_kind, input letter_index,
                    input stat_value, input last_result, output ready);
endinterface

// ===== rtl/core/tcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_front - input classifier
// Accepts text bytes, classifies them and holds one classified entry.
// ----------------------------------------------------------------------------
module tcs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcs_in_if.sink           i_in,
    output logic             o_valid,
    input  logic             i_ready,
    output tcs_pkg::t_qentry o_entry
);

    logic             r_valid;
    tcs_pkg::t_qentry r_entry;
    tcs_pkg::t_qentry n_entry;
    logic [7:0]       b;

    assign b          = i_in.text_byte;
    assign i_in.ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_entry    = r_entry;

    always_comb begin
        n_entry.letter = 5'd0;
        if (i_in.end_of_text) begin
            n_entry.cls = tcs_pkg::CLS_EOT;
        end else if (b == tcs_pkg::CHAR_NL) begin
            n_entry.cls = tcs_pkg::CLS_NEWLINE;
        end else if (b >= tcs_pkg::CHAR_UPPER_A && b <= tcs_pkg::CHAR_UPPER_Z) begin
            n_entry.cls    = tcs_pkg::CLS_UPPER;
            n_entry.letter = 5'(b - tcs_pkg::CHAR_UPPER_A);
        end else if (b >= tcs_pkg::CHAR_LOWER_A && b <= tcs_pkg::CHAR_LOWER_Z) begin
            n_entry.cls    = tcs_pkg::CLS_LOWER;
            n_entry.letter = 5'(b - tcs_pkg::CHAR_LOWER_A);
        end else if (b >= tcs_pkg::CHAR_ZERO && b <= tcs_pkg::CHAR_NINE) begin
            n_entry.cls = tcs_pkg::CLS_DIGIT;
        end else begin
            n_entry.cls = tcs_pkg::CLS_OTHER;   // includes 0x80-0xFF
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_entry <= n_entry;
        end
    end

endmodule

// ===== rtl/core/tcs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_queue - classified entry queue
// Small FIFO that decouples the classifier from the statistics engine.
// ----------------------------------------------------------------------------
module tcs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tcs_pkg::t_qentry i_entry,
    output logic             o_valid,
    input  logic             i_ready,
    output tcs_pkg::t_qentry o_entry
);

    localparam int unsigned CW = tcs_pkg::QUEUE_AW + 1;

    tcs_pkg::t_qentry                r_mem [tcs_pkg::QUEUE_DEPTH];
    logic [tcs_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [tcs_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [CW-1:0]                   r_count;
    logic                            push;
    logic                            pop;

    assign o_ready = r_count != CW'(tcs_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== rtl/core/tcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcs_back - statistics engine
// Updates class counters, line figures and the letter bin memory, and walks
// the report at end of text.
// ----------------------------------------------------------------------------
module tcs_back #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tcs_pkg::t_qentry i_entry,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tcs_pkg::t_result o_result
);

    localparam int unsigned W  = COUNT_WIDTH;
    localparam int unsigned AW = tcs_pkg::BIN_AW;
    localparam int unsigned IW = tcs_pkg::REP_IW;
    localparam logic [W-1:0] SHORT_INIT =
        (W > 21) ? W'(tcs_pkg::SHORTEST_INIT) : {W{1'b1}};

    typedef enum logic [1:0] {
        ST_RUN,
        ST_REP_READ,
        ST_REP_LOAD
    } t_state;

    function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
        return (&v) ? v : v + {{(W-1){1'b0}}, 1'b1};
    endfunction

    function automatic logic [31:0] clamp32(input logic [W-1:0] v);
        logic [W+31:0] ext;
        ext = {32'd0, v};
        return (|ext[W+31:32]) ? 32'hFFFF_FFFF : ext[31:0];
    endfunction

    t_state           r_state;
    logic [IW-1:0]    r_rep_idx;
    logic [W-1:0]     r_upper, r_lower, r_digit, r_other;
    logic [W-1:0]     r_lines, r_cur_len, r_longest, r_shortest;

    logic [W-1:0]     r_bins [tcs_pkg::BIN_DEPTH];
    logic             r_bin_vld [tcs_pkg::BIN_DEPTH];
    logic [W-1:0]     r_rd_data;
    logic             r_rd_vld;
    logic             r_b_valid;
    logic [AW-1:0]    r_b_addr;
    logic             r_last_wr_valid;
    logic [AW-1:0]    r_last_wr_addr;
    logic [W-1:0]     r_last_wr_data;

    logic             r_out_valid;
    tcs_pkg::t_result r_result;

    logic             pop;
    logic             out_free;
    logic [AW-1:0]    letter_addr;
    logic [AW-1:0]    rep_addr;
    logic [AW-1:0]    rd_addr;
    logic [W-1:0]     bin_cur;
    logic [W-1:0]     bin_next;
    logic [W-1:0]     rep_bin;
    logic [3:0]       rep_kind;
    logic [4:0]       rep_letter;
    logic [W-1:0]     rep_value;
    logic             is_letter;

    assign o_ready     = r_state == ST_RUN;
    assign pop         = o_ready && i_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    assign is_letter   = i_entry.cls == tcs_pkg::CLS_UPPER ||
                         i_entry.cls == tcs_pkg::CLS_LOWER;
    assign letter_addr = (i_entry.cls == tcs_pkg::CLS_LOWER)
                       ? AW'(i_entry.letter) + AW'(tcs_pkg::NUM_LETTERS)
                       : AW'(i_entry.letter);
    // upper bins follow the scalars, lower bins follow the upper bins
    assign rep_addr    = (r_rep_idx >= IW'(tcs_pkg::SCALAR_COUNT))
                       ? AW'(r_rep_idx - IW'(tcs_pkg::SCALAR_COUNT)) : '0;
    assign rd_addr     = (r_state == ST_RUN) ? letter_addr : rep_addr;

    // read-modify-write: forward the write of the previous item
    assign bin_cur  = (r_last_wr_valid && r_last_wr_addr == r_b_addr) ? r_last_wr_data
                    : (r_rd_vld ? r_rd_data : '0);
    assign bin_next = sat_inc(bin_cur);
    assign rep_bin  = r_rd_vld ? r_rd_data : '0;

    always_comb begin
        if (r_rep_idx < IW'(tcs_pkg::SCALAR_COUNT)) begin
            rep_kind   = 4'(r_rep_idx);
            rep_letter = 5'd0;
        end else if (r_rep_idx < IW'(tcs_pkg::SCALAR_COUNT + tcs_pkg::NUM_LETTERS)) begin
            rep_kind   = tcs_pkg::KIND_UPPER_BIN;
            rep_letter = 5'(r_rep_idx - IW'(tcs_pkg::SCALAR_COUNT));
        end else begin
            rep_kind   = tcs_pkg::KIND_LOWER_BIN;
            rep_letter = 5'(r_rep_idx - IW'(tcs_pkg::SCALAR_COUNT + tcs_pkg::NUM_LETTERS));
        end
        case (rep_kind)
            tcs_pkg::KIND_UPPER:    rep_value = r_upper;
            tcs_pkg::KIND_LOWER:    rep_value = r_lower;
            tcs_pkg::KIND_DIGIT:    rep_value = r_digit;
            tcs_pkg::KIND_OTHER:    rep_value = r_other;
            tcs_pkg::KIND_LINES:    rep_value = r_lines;
            tcs_pkg::KIND_LONGEST:  rep_value = r_longest;
            tcs_pkg::KIND_SHORTEST: rep_value = r_shortest;
            default:                rep_value = rep_bin;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_RUN;
            r_rep_idx       <= '0;
            r_upper         <= '0;
            r_lower         <= '0;
            r_digit         <= '0;
            r_other         <= '0;
            r_lines         <= '0;
            r_cur_len       <= '0;
            r_longest       <= '0;
            r_shortest      <= SHORT_INIT;
            r_b_valid       <= 1'b0;
            r_last_wr_valid <= 1'b0;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < tcs_pkg::BIN_DEPTH; i++) begin
                r_bin_vld[i] <= 1'b0;
            end
        end else begin
            r_rd_vld        <= r_bin_vld[rd_addr];
            r_b_valid       <= pop && is_letter;
            r_b_addr        <= letter_addr;
            r_last_wr_valid <= r_b_valid;
            r_last_wr_addr  <= r_b_addr;
            if (r_b_valid) begin
                r_bin_vld[r_b_addr] <= 1'b1;
            end
            // in the load state the output register is refilled instead
            if (r_out_valid && i_out_ready && r_state != ST_REP_LOAD) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_RUN: begin
                    if (pop) begin
                        case (i_entry.cls)
                            tcs_pkg::CLS_UPPER: begin
                                r_cur_len <= sat_inc(r_cur_len);
                                r_upper   <= sat_inc(r_upper);
                            end
                            tcs_pkg::CLS_LOWER: begin
                                r_cur_len <= sat_inc(r_cur_len);
                                r_lower   <= sat_inc(r_lower);
                            end
                            tcs_pkg::CLS_DIGIT: begin
                                r_cur_len <= sat_inc(r_cur_len);
                                r_digit   <= sat_inc(r_digit);
                            end
                            tcs_pkg::CLS_OTHER: begin
                                r_cur_len <= sat_inc(r_cur_len);
                                r_other   <= sat_inc(r_other);
                            end
                            tcs_pkg::CLS_NEWLINE, tcs_pkg::CLS_EOT: begin
                                // close the line
                                if (r_cur_len < r_shortest) begin
                                    r_shortest <= r_cur_len;
                                end
                                if (r_cur_len > r_longest) begin
                                    r_longest <= r_cur_len;
                                end
                                r_cur_len <= '0;
                                r_lines   <= sat_inc(r_lines);
                                if (i_entry.cls == tcs_pkg::CLS_EOT) begin
                                    r_state   <= ST_REP_READ;
                                    r_rep_idx <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_REP_READ: begin
                    r_state <= ST_REP_LOAD;
                end
                ST_REP_LOAD: begin
                    if (out_free) begin
                        r_out_valid     <= 1'b1;
                        r_result.kind   <= rep_kind;
                        r_result.letter <= rep_letter;
                        r_result.value  <= clamp32(rep_value);
                        r_result.last   <= r_rep_idx == IW'(tcs_pkg::REPORT_LEN - 1);
                        if (r_rep_idx == IW'(tcs_pkg::REPORT_LEN - 1)) begin
                            r_state         <= ST_RUN;
                            r_upper         <= '0;
                            r_lower         <= '0;
                            r_digit         <= '0;
                            r_other         <= '0;
                            r_lines         <= '0;
                            r_cur_len       <= '0;
                            r_longest       <= '0;
                            r_shortest      <= SHORT_INIT;
                            for (int i = 0; i < tcs_pkg::BIN_DEPTH; i++) begin
                                r_bin_vld[i] <= 1'b0;
                            end
                        end else begin
                            r_rep_idx <= r_rep_idx + 1'b1;
                            r_state   <= ST_REP_READ;
                        end
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_bins[rd_addr];
        if (r_b_valid) begin
            r_bins[r_b_addr] <= bin_next;
        end
        r_last_wr_data <= bin_next;
    end

endmodule

// ===== rtl/core/text_character_statistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_character_statistics - character class and letter histogram
// Counts byte classes, letter bins and line figures; reports them at end of text.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one transfer per text byte; end_of_text = 1 closes the last line
//           (possibly empty) and starts the report, text_byte is then ignored.
//   o_out : 59 transfers per report: upper, lower, digit, other, lines,
//           longest, shortest, then 26 upper bins and 26 lower bins;
//           last_result marks the final one. Values saturate to 32 bits.
// Throughput: one byte per cycle sustained while no report is being
//   walked. A byte passes the classifier register, the 4-entry queue and
//   the counter stage; letter bins live in a 52-entry memory updated by
//   read-modify-write with forwarding.
// Report: each result takes a bin memory read, then an output load; bytes
//   keep being taken until the queue fills.
// Stall: a stalled receiver holds the output register; the report pauses.
// Reset: clears all counters and bin valid flags at once; shortest line
//   starts at 2^21 or the counter maximum, whichever is smaller. All
//   statistics return to this state after the last result.
// ----------------------------------------------------------------------------
module text_character_statistics #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcs_in_if.sink    i_in,
    tcs_out_if.source o_out
);

    logic             f_valid;
    logic             f_ready;
    tcs_pkg::t_qentry f_entry;
    logic             q_valid;
    logic             q_ready;
    tcs_pkg::t_qentry q_entry;
    logic             b_out_valid;
    tcs_pkg::t_result b_result;

    // classify each byte into an entry
    tcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_entry (f_entry)
    );

    // decouples classifier from the engine during the report walk
    tcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_entry (f_entry),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_entry (q_entry)
    );

    // counters, bins and report sequencer
    tcs_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_entry     (q_entry),
        .o_out_valid (b_out_valid),
        .i_out_ready (o_out.ready),
        .o_result    (b_result)
    );

    assign o_out.valid        = b_out_valid;
    assign o_out.stat_kind    = b_result.kind;
    assign o_out.letter_index = b_result.letter;
    assign o_out.stat_value   = b_result.value;
    assign o_out.last_result  = b_result.last;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - character class and letter histogram checker
// Streams text through text_character_statistics and scores every report
// entry against a cycle-free prediction of the statistics. Directed texts
// hit the class boundaries, empty text and an empty final line. Random texts
// follow them, with bursty input and a receiver that stalls in patterns.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned COUNT_WIDTH    = 32;
    localparam int unsigned RANDOM_ITEMS   = 230;
    localparam int unsigned WATCHDOG_LIMIT = 1000;   // cycles with no transfer
    localparam int unsigned TAIL_CYCLES    = 200;    // quiet tail after the last report

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // one input transfer; hold_for_drain keeps it back until every pending
    // report entry has been received
    typedef struct {
        logic [7:0] text_byte;
        logic       end_of_text;
        logic       hold_for_drain;
    } t_text_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tcs_in_if  in_if ();
    tcs_out_if out_if ();

    text_character_statistics #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Statistics predictor
    // ------------------------------------------------------------------------
    // Class tallies indexed by t_cls (upper, lower, digit, other); letter
    // bins indexed [case][letter] with case 0 upper, 1 lower.
    logic [COUNT_WIDTH-1:0] class_tally [4];
    logic [COUNT_WIDTH-1:0] letter_bins [2][tcs_pkg::NUM_LETTERS];
    logic [COUNT_WIDTH-1:0] lines_closed;
    logic [COUNT_WIDTH-1:0] line_length;
    logic [COUNT_WIDTH-1:0] longest_seen;
    logic [COUNT_WIDTH-1:0] shortest_seen;

    tcs_pkg::t_result report_entries_due[$];
    t_text_item       pending_items[$];

    int error_count       = 0;
    int results_predicted = 0;   // both only move by nonblocking update,
    int results_seen      = 0;   // so the drain check is order-free
    int bytes_sent        = 0;
    int texts_reported    = 0;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    // wide counters report clamped to the 32-bit result field
    function automatic logic [31:0] clamp_value(input logic [COUNT_WIDTH-1:0] c);
        logic [63:0] wide;
        wide = 64'(c);
        return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    function automatic tcs_pkg::t_cls classify(input logic [7:0] b);
        if (b == tcs_pkg::CHAR_NL)
            return tcs_pkg::CLS_NEWLINE;
        if (b >= tcs_pkg::CHAR_UPPER_A && b <= tcs_pkg::CHAR_UPPER_Z)
            return tcs_pkg::CLS_UPPER;
        if (b >= tcs_pkg::CHAR_LOWER_A && b <= tcs_pkg::CHAR_LOWER_Z)
            return tcs_pkg::CLS_LOWER;
        if (b >= tcs_pkg::CHAR_ZERO && b <= tcs_pkg::CHAR_NINE)
            return tcs_pkg::CLS_DIGIT;
        return tcs_pkg::CLS_OTHER;   // includes 0x80-0xFF
    endfunction

    function automatic void clear_stats();
        logic [63:0] init_wide;
        for (int c = 0; c < 4; c++) class_tally[c] = '0;
        for (int k = 0; k < 2; k++)
            for (int i = 0; i < tcs_pkg::NUM_LETTERS; i++) letter_bins[k][i] = '0;
        lines_closed = '0;
        line_length  = '0;
        longest_seen = '0;
        // shortest starts at 2^21 unless the counter cannot hold it
        init_wide     = 64'(tcs_pkg::SHORTEST_INIT);
        shortest_seen = (init_wide < 64'(COUNT_MAX)) ? COUNT_WIDTH'(tcs_pkg::SHORTEST_INIT)
                                                     : COUNT_MAX;
    endfunction

    function automatic void close_line();
        if (line_length < shortest_seen) shortest_seen = line_length;
        if (line_length > longest_seen)  longest_seen  = line_length;
        line_length  = '0;
        lines_closed = sat_inc(lines_closed);
    endfunction

    function automatic void push_entry(input logic [3:0] kind, input int letter,
                                       input logic [COUNT_WIDTH-1:0] value,
                                       input logic last);
        tcs_pkg::t_result r;
        r.kind   = kind;
        r.letter = 5'(letter);
        r.value  = clamp_value(value);
        r.last   = last;
        report_entries_due.push_back(r);
    endfunction

    // Applies one accepted input item; returns how many report entries it adds.
    function automatic int account_text_item(input t_text_item item);
        tcs_pkg::t_cls cls;
        if (!item.end_of_text) begin
            cls = classify(item.text_byte);
            if (cls == tcs_pkg::CLS_NEWLINE) begin
                close_line();
                return 0;
            end
            line_length = sat_inc(line_length);
            class_tally[cls] = sat_inc(class_tally[cls]);
            if (cls == tcs_pkg::CLS_UPPER)
                letter_bins[0][item.text_byte - tcs_pkg::CHAR_UPPER_A] =
                    sat_inc(letter_bins[0][item.text_byte - tcs_pkg::CHAR_UPPER_A]);
            else if (cls == tcs_pkg::CLS_LOWER)
                letter_bins[1][item.text_byte - tcs_pkg::CHAR_LOWER_A] =
                    sat_inc(letter_bins[1][item.text_byte - tcs_pkg::CHAR_LOWER_A]);
            return 0;
        end
        // end of text: close the final line (may be empty), then report
        close_line();
        push_entry(tcs_pkg::KIND_UPPER,    0, class_tally[tcs_pkg::CLS_UPPER], 1'b0);
        push_entry(tcs_pkg::KIND_LOWER,    0, class_tally[tcs_pkg::CLS_LOWER], 1'b0);
        push_entry(tcs_pkg::KIND_DIGIT,    0, class_tally[tcs_pkg::CLS_DIGIT], 1'b0);
        push_entry(tcs_pkg::KIND_OTHER,    0, class_tally[tcs_pkg::CLS_OTHER], 1'b0);
        push_entry(tcs_pkg::KIND_LINES,    0, lines_closed,  1'b0);
        push_entry(tcs_pkg::KIND_LONGEST,  0, longest_seen,  1'b0);
        push_entry(tcs_pkg::KIND_SHORTEST, 0, shortest_seen, 1'b0);
        for (int i = 0; i < tcs_pkg::NUM_LETTERS; i++)
            push_entry(tcs_pkg::KIND_UPPER_BIN, i, letter_bins[0][i], 1'b0);
        for (int i = 0; i < tcs_pkg::NUM_LETTERS; i++)
            push_entry(tcs_pkg::KIND_LOWER_BIN, i, letter_bins[1][i],
                       i == tcs_pkg::NUM_LETTERS - 1);
        clear_stats();
        return tcs_pkg::REPORT_LEN;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    int items_queued = 0;
    logic hold_next  = 1'b0;   // next queued item waits for a full drain

    task automatic add_item(input logic [7:0] b, input logic eot);
        t_text_item it;
        it.text_byte      = b;
        it.end_of_text    = eot;
        it.hold_for_drain = hold_next;
        hold_next         = 1'b0;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Mostly letters, with digits, printable punctuation, high bytes and
    // fully random bytes (which may also be newlines) mixed in.
    function automatic logic [7:0] random_text_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(tcs_pkg::CHAR_UPPER_A, tcs_pkg::CHAR_UPPER_Z));
            3, 4, 5: return 8'($urandom_range(tcs_pkg::CHAR_LOWER_A, tcs_pkg::CHAR_LOWER_Z));
            6:       return 8'($urandom_range(tcs_pkg::CHAR_ZERO, tcs_pkg::CHAR_NINE));
            7:       return 8'($urandom_range(0, 255));
            8:       return 8'($urandom_range(8'h80, 8'hFF));
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    initial begin
        int n_lines;
        int len;
        int text_no;
        int random_start;

        clear_stats();

        // Directed: empty text right after reset; the byte riding with
        // end of text is 0xFF and must be ignored. One empty line.
        add_item(8'hFF, 1'b1);

        // Directed: class boundaries on both sides of every range, NUL,
        // 0xFF and 0x80 as other, then an empty final line. The first byte
        // waits for the previous report to drain completely.
        hold_next = 1'b1;
        add_item(tcs_pkg::CHAR_UPPER_A, 1'b0);
        add_item(tcs_pkg::CHAR_UPPER_Z, 1'b0);
        add_item(tcs_pkg::CHAR_LOWER_A, 1'b0);
        add_item(tcs_pkg::CHAR_LOWER_Z, 1'b0);
        add_item(tcs_pkg::CHAR_ZERO,    1'b0);
        add_item(tcs_pkg::CHAR_NINE,    1'b0);
        add_item(8'h00,                 1'b0);
        add_item(8'hFF,                 1'b0);
        add_item(8'h80,                 1'b0);
        add_item(8'h40,                 1'b0);   // just below 'A'
        add_item(8'h5B,                 1'b0);   // just above 'Z'
        add_item(8'h60,                 1'b0);   // just below 'a'
        add_item(8'h7B,                 1'b0);   // just above 'z'
        add_item(8'h2F,                 1'b0);   // just below '0'
        add_item(8'h3A,                 1'b0);   // just above '9'
        add_item(tcs_pkg::CHAR_NL,      1'b0);
        add_item(8'h71,                 1'b0);   // 'q'
        add_item(8'h51,                 1'b0);   // 'Q'
        add_item(tcs_pkg::CHAR_NL,      1'b0);
        add_item(tcs_pkg::CHAR_NL,      1'b1);   // newline byte ignored under end of text

        // Random texts: a few lines each, mostly short, some long; the last
        // line may or may not end in a newline before end of text.
        random_start = items_queued;
        text_no = 0;
        while (items_queued - random_start < RANDOM_ITEMS) begin
            if (text_no == 3) hold_next = 1'b1;
            n_lines = $urandom_range(0, 5);
            for (int l = 0; l < n_lines; l++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
                for (int c = 0; c < len; c++) add_item(random_text_byte(), 1'b0);
                if (l != n_lines - 1 || $urandom_range(0, 1) == 1)
                    add_item(tcs_pkg::CHAR_NL, 1'b0);
            end
            add_item(8'($urandom_range(0, 255)), 1'b1);
            text_no++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || report_entries_due.size() != 0)
            @(posedge i_clk);
        // quiet tail: catches stray results after the last report
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (report_entries_due.size() != 0) begin
            $error("%0d report entries never arrived", report_entries_due.size());
            error_count++;
        end
        $display("Run covered %0d texts, %0d text bytes and %0d report entries checked.",
                 texts_reported, bytes_sent, results_seen);
        $display("Input ran in random bursts; output stalled on rotating ready patterns.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver: bursts of random length separated by random gaps; a
    // presented item stays on the bus until it transfers.
    // ------------------------------------------------------------------------
    int gap_left   = 0;
    int burst_left = 1;

    always @(posedge i_clk) begin
        t_text_item sent;
        logic       load;
        int         added;
        if (!i_rst_n) begin
            in_if.valid       <= 1'b0;
            in_if.text_byte   <= '0;
            in_if.end_of_text <= 1'b0;
        end else if (!(in_if.valid && !in_if.ready)) begin
            added = 0;
            if (in_if.valid) begin
                // transfer at this edge: predict, then maybe start a gap
                sent  = pending_items.pop_front();
                added = account_text_item(sent);
                if (sent.end_of_text) texts_reported++;
                else                  bytes_sent++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
                end
            end
            results_predicted <= results_predicted + added;

            load = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_items.size() != 0)
                load = !(pending_items[0].hold_for_drain &&
                         (results_predicted + added != results_seen));
            in_if.valid <= load;
            if (load) begin
                in_if.text_byte   <= pending_items[0].text_byte;
                in_if.end_of_text <= pending_items[0].end_of_text;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready follows a rotating 8-bit pattern that is redrawn each
    // time pattern_age wraps; about a third of the patterns never stall.
    // ------------------------------------------------------------------------
    logic [7:0] stall_pattern;
    int         pattern_age;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready  <= 1'b0;
            stall_pattern <= 8'hFF;
            pattern_age   <= 0;
        end else begin
            if (pattern_age == 63) begin
                pattern_age   <= 0;
                stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF
                                                             : (8'($urandom) | 8'h01);
            end else begin
                pattern_age   <= pattern_age + 1;
                stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
            end
            out_if.ready <= stall_pattern[0];
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: each transfer is scored against the oldest prediction.
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        tcs_pkg::t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen <= results_seen + 1;
            if (report_entries_due.size() == 0) begin
                $error("unexpected result: kind %0d letter %0d value 0x%0h last %0b",
                       out_if.stat_kind, out_if.letter_index, out_if.stat_value,
                       out_if.last_result);
                error_count++;
            end else begin
                want = report_entries_due.pop_front();
                check_field("stat_kind",    32'(want.kind),   32'(out_if.stat_kind));
                check_field("letter_index", 32'(want.letter), 32'(out_if.letter_index));
                check_field("stat_value",   want.value,       out_if.stat_value);
                check_field("last_result",  32'(want.last),   32'(out_if.last_result));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer on either channel ends the run.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles, %0d inputs and %0d results outstanding",
                   idle_cycles, pending_items.size(), report_entries_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== text_character_statistics.f =====
rtl/core/tcs_pkg.sv
rtl/core/tcs_in_if.sv
rtl/core/tcs_out_if.sv
rtl/core/tcs_front.sv
rtl/core/tcs_queue.sv
rtl/core/tcs_back.sv
rtl/core/text_character_statistics.sv
dv/testbench.sv
